[src/toeq_pkg.sv]
// ----------------------------------------------------------------------------
// toeq_pkg
// Shared types and codes for the time ordered event queue.
// ----------------------------------------------------------------------------
package toeq_pkg;

  localparam int DepthDefault = 16;

  localparam int DevW   = 8;
  localparam int CodeW  = 16;
  localparam int TimeW  = 32;
  localparam int KindW  = 2;
  localparam int StatW  = 2;
  localparam int CountW = 5;

  // Operation codes carried by the kind field
  localparam logic [KindW-1:0] KIND_INSERT = 2'd0;
  localparam logic [KindW-1:0] KIND_POP    = 2'd1;
  localparam logic [KindW-1:0] KIND_REMOVE = 2'd2;

  // Status codes of a result word
  localparam logic [StatW-1:0] ST_DONE    = 2'd0;
  localparam logic [StatW-1:0] ST_FULL    = 2'd1;
  localparam logic [StatW-1:0] ST_EMPTY   = 2'd2;
  localparam logic [StatW-1:0] ST_NOMATCH = 2'd3;

  typedef struct packed {
    logic [DevW-1:0]  dev;
    logic [CodeW-1:0] code;
    logic [TimeW-1:0] tstamp;
  } entry_t;

  // Broadcast command to every cell of the chain
  typedef struct packed {
    logic ins;   // insert the broadcast entry in order
    logic rem;   // close the gap from the right where flagged
  } cell_ctl_t;

endpackage

[src/toeq_cell.sv]
// ----------------------------------------------------------------------------
// toeq_cell
// One slot of the sorted chain: holds an entry, compares it with the broadcast
// word and moves data to or from its neighbors.
// ----------------------------------------------------------------------------
module toeq_cell
  import toeq_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      occ,
  input  entry_t    new_entry,
  input  entry_t    left_entry,
  input  logic      left_le,
  input  entry_t    right_entry,
  input  logic      rm_take,
  output entry_t    entry,
  output entry_t    entry_next,
  output logic      le,
  output logic      match
);

  assign le    = occ && (entry.tstamp <= new_entry.tstamp);
  assign match = occ && (entry.dev == new_entry.dev);

  always_comb begin
    entry_next = entry;
    if (ctl.ins) begin
      // keep while ours sorts first, load at the boundary, shift right past it
      if (!le) begin
        entry_next = left_le ? new_entry : left_entry;
      end
    end else if (ctl.rem) begin
      if (rm_take) begin
        entry_next = right_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

[src/time_ordered_event_queue_core.sv]
// ----------------------------------------------------------------------------
// time_ordered_event_queue_core
// Bounded event queue kept in ascending time order by a chain of slot cells.
// ----------------------------------------------------------------------------
//
//  channel | words carried                                  | handshake
//  --------+------------------------------------------------+------------------
//  in      | kind, device_id, code_value, event_time        | in_valid/in_stall
//  out     | head_valid, head_device, head_code, head_time, | out_valid/out_stall
//          | entry_count, status                            |
//
// For each accepted word, every cell updates at the accepting edge
// and the result word is registered at that same edge, showing next cycle.
// A new word is taken every cycle as long as the result register drains; the
// single output register sets that figure.
// in_stall is high only while a result word waits under out_stall.
// Reset clears the fill count and the output valid; slot contents are left
// as they are and only slots below the count are ever shown.
// ----------------------------------------------------------------------------
module time_ordered_event_queue_core
  import toeq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DepthDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [KindW-1:0]  kind,
  input  logic [DevW-1:0]   device_id,
  input  logic [CodeW-1:0]  code_value,
  input  logic [TimeW-1:0]  event_time,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              head_valid,
  output logic [DevW-1:0]   head_device,
  output logic [CodeW-1:0]  head_code,
  output logic [TimeW-1:0]  head_time,
  output logic [CountW-1:0] entry_count,
  output logic [StatW-1:0]  status
);

  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CntW-1:0] FullCount = CntW'(QUEUE_DEPTH);

  logic [CntW-1:0] fill_level;
  logic [CntW-1:0] fill_level_next;
  logic            accept;
  logic            is_empty;
  logic            is_full;
  logic            any_match;
  logic [StatW-1:0] status_next;
  cell_ctl_t       ctl;
  entry_t          new_entry;

  entry_t                 cell_q [QUEUE_DEPTH];
  entry_t                 cell_d [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] occ;
  logic [QUEUE_DEPTH-1:0] le_vec;
  logic [QUEUE_DEPTH-1:0] match_vec;
  logic [QUEUE_DEPTH-1:0] rm_vec;
  logic [QUEUE_DEPTH-1:0] below_vec;
  logic [QUEUE_DEPTH-1:0] take_vec;

  // hold the input while a result waits on a stalled output
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign new_entry = '{dev: device_id, code: code_value, tstamp: event_time};

  assign is_empty  = (fill_level == '0);
  assign is_full   = (fill_level == FullCount);
  assign any_match = |match_vec;

  // pop removes slot 0; remove closes the gap at the first matching slot
  assign rm_vec    = (kind == KIND_POP) ? QUEUE_DEPTH'(1) : match_vec;
  // bits strictly below the lowest set bit; all ones when nothing is set
  assign below_vec = (rm_vec - QUEUE_DEPTH'(1)) & ~rm_vec;
  assign take_vec  = ~below_vec;

  always_comb begin
    ctl             = '0;
    status_next     = ST_DONE;
    fill_level_next = fill_level;
    case (kind)
      KIND_INSERT: begin
        if (is_full) begin
          status_next = ST_FULL;
        end else begin
          ctl.ins         = accept;
          fill_level_next = fill_level + CntW'(1);
        end
      end
      KIND_POP: begin
        if (is_empty) begin
          status_next = ST_EMPTY;
        end else begin
          ctl.rem         = accept;
          fill_level_next = fill_level - CntW'(1);
        end
      end
      KIND_REMOVE: begin
        if (is_empty) begin
          status_next = ST_EMPTY;
        end else if (!any_match) begin
          status_next = ST_NOMATCH;
        end else begin
          ctl.rem         = accept;
          fill_level_next = fill_level - CntW'(1);
        end
      end
      default: begin
        status_next = ST_DONE;
      end
    endcase
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t left_e;
    entry_t right_e;
    logic   left_le_i;

    assign occ[i] = (CntW'(i) < fill_level);

    if (i == 0) begin : g_first
      assign left_e    = new_entry;
      assign left_le_i = 1'b1;
    end else begin : g_mid
      assign left_e    = cell_q[i-1];
      assign left_le_i = le_vec[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_e = '0;
    end else begin : g_inner
      assign right_e = cell_q[i+1];
    end

    toeq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .occ         (occ[i]),
      .new_entry   (new_entry),
      .left_entry  (left_e),
      .left_le     (left_le_i),
      .right_entry (right_e),
      .rm_take     (take_vec[i]),
      .entry       (cell_q[i]),
      .entry_next  (cell_d[i]),
      .le          (le_vec[i]),
      .match       (match_vec[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_level <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        fill_level <= fill_level_next;
        out_valid  <= 1'b1;
      end else if (!out_stall) begin
        out_valid  <= 1'b0;
      end
    end
  end

  // result payload: advance only on accept, hold otherwise
  always_ff @(posedge clk) begin
    if (accept) begin
      head_valid  <= (fill_level_next != '0);
      entry_count <= CountW'(fill_level_next);
      status      <= status_next;
      if (fill_level_next != '0) begin
        head_device <= cell_d[0].dev;
        head_code   <= cell_d[0].code;
        head_time   <= cell_d[0].tstamp;
      end else begin
        head_device <= '0;
        head_code   <= '0;
        head_time   <= '0;
      end
    end
  end

endmodule

[src/toeq_checker.sv]
// ----------------------------------------------------------------------------
// toeq_checker
// Port-level checks for the time ordered event queue, bound to the top level.
// ----------------------------------------------------------------------------
module toeq_checker
  import toeq_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic              head_valid,
  input logic [DevW-1:0]   head_device,
  input logic [CodeW-1:0]  head_code,
  input logic [TimeW-1:0]  head_time,
  input logic [CountW-1:0] entry_count,
  input logic [StatW-1:0]  status
);

  // input is held back only by a waiting result word
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("in_stall without a waiting result word");

  // every accepted word yields a result word next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted word gave no result");

  // an empty queue shows a zero head
  a_empty_head: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !head_valid) |->
      (head_device == '0 && head_code == '0 && head_time == '0))
    else $error("empty queue shows a nonzero head");

  // a refused insert means the queue holds events; an empty flag means none
  a_status_head: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((status != ST_FULL || head_valid) &&
                   (status != ST_EMPTY || !head_valid)))
    else $error("status disagrees with head_valid");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(head_time) && $stable(entry_count) && $stable(status)))
    else $error("stalled result word changed");

endmodule

bind time_ordered_event_queue_core toeq_checker u_toeq_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .head_valid  (head_valid),
  .head_device (head_device),
  .head_code   (head_code),
  .head_time   (head_time),
  .entry_count (entry_count),
  .status      (status)
);
